>>> src/acdsm_pkg.sv
// shared constants for the audio channel dma sequencer
package acdsm_pkg;

    localparam int WORD_W   = 16;
    localparam int VOL_W    = 7;
    localparam int PHASE_W  = 6;
    localparam int LEVEL_W  = 8;
    localparam int MODE_W   = 3;
    localparam int CMD_W    = 2;
    localparam int CFG_IDX_W = 3;

    // channel modes
    localparam logic [MODE_W-1:0] MODE_DISABLED   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_DUMMY_WAIT = 3'd1;
    localparam logic [MODE_W-1:0] MODE_HIGH       = 3'd2;
    localparam logic [MODE_W-1:0] MODE_LOW        = 3'd3;
    localparam logic [MODE_W-1:0] MODE_DMA_WAIT   = 3'd5;

    // commands
    localparam logic [CMD_W-1:0] CMD_TICK      = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DMA_DATA  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CPU_WRITE = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD_RELOAD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LENGTH_RELOAD = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_VOLUME_LEVEL  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ATTACH_PERIOD = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ATTACH_VOLUME = 3'd4;

    localparam logic [VOL_W-1:0] VOL_FULL = 7'd64;

endpackage

>>> src/audio_channel_dma_state_machine_top.sv
// audio channel dma sequencer: input register, channel state update, result register
//
// usage: one transaction on the input channel (command, sample_word, dma_on,
// irq_pending) gives exactly one transaction on the output channel (level,
// level_gate, irq_request, dma_request, pointer_reload) showing the channel
// after that command. command tick runs the pwm gate and the channel state
// machine, dma data and cpu write load the holding word.
// order: the input transaction goes into the input register, then the update
// writes the result register. throughput: one transaction per cycle while the
// receiver keeps out_ready high.
// when the receiver stalls, the result register holds and one more item waits
// in the input register; in_ready drops only when both are full.
// reset: channel disabled, counters and words zero, gate open, both registers
// empty. configuration is written through cfg_write_en, cfg_index and cfg_data
// while the block is idle (user's duty, not enforced); unknown indexes are ignored.
module audio_channel_dma_state_machine_top
    import acdsm_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_write_en,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [WORD_W-1:0]        cfg_data,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [CMD_W-1:0]         command,
    input  logic [WORD_W-1:0]        sample_word,
    input  logic                     dma_on,
    input  logic                     irq_pending,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [LEVEL_W-1:0] level,
    output logic                     level_gate,
    output logic                     irq_request,
    output logic                     dma_request,
    output logic                     pointer_reload
);

    // configuration
    logic [WORD_W-1:0] period_reload_reg;
    logic [WORD_W-1:0] length_reload_reg;
    logic [VOL_W-1:0]  volume_level_reg;
    logic              attach_period_reg;
    logic              attach_volume_reg;

    // input register
    logic              in_valid_reg;
    logic [CMD_W-1:0]  cmd_reg;
    logic [WORD_W-1:0] word_reg;
    logic              dma_reg;
    logic              ip_reg;

    // channel state
    logic [MODE_W-1:0]  mode_reg, mode_next;
    logic [WORD_W-1:0]  holding_reg, holding_next;
    logic [WORD_W-1:0]  playing_reg, playing_next;
    logic [WORD_W-1:0]  period_cnt_reg, period_cnt_next;
    logic [WORD_W-1:0]  length_cnt_reg, length_cnt_next;
    logic [VOL_W-1:0]   vol_hold_reg, vol_hold_next;
    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic               gate_reg, gate_next;
    logic               wanted_reg, wanted_next;
    logic               armed_reg, armed_next;
    logic               reload_reg, reload_next;
    logic [LEVEL_W-1:0] level_hold_reg, level_hold_next;
    logic               irq_next;
    logic               reload_out_next;

    // result register
    logic               out_valid_reg;
    logic [LEVEL_W-1:0] level_reg;
    logic               gate_out_reg;
    logic               irq_out_reg;
    logic               dma_out_reg;
    logic               reload_out_reg;

    logic               advance;
    logic [PHASE_W:0]   phase_inc;
    logic [WORD_W-1:0]  period_dec;
    logic [WORD_W-1:0]  len_dec;
    logic               napnav;
    logic               dma;
    logic               ip;

    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    assign dma       = dma_reg;
    assign ip        = ip_reg;
    assign phase_inc = {1'b0, phase_reg} + {{PHASE_W{1'b0}}, 1'b1};
    assign period_dec = period_cnt_reg - {{(WORD_W-1){1'b0}}, 1'b1};
    assign napnav    = attach_volume_reg || !attach_period_reg;

    always_comb
    begin
        mode_next       = mode_reg;
        holding_next    = holding_reg;
        playing_next    = playing_reg;
        period_cnt_next = period_cnt_reg;
        length_cnt_next = length_cnt_reg;
        vol_hold_next   = vol_hold_reg;
        phase_next      = phase_reg;
        gate_next       = gate_reg;
        wanted_next     = wanted_reg;
        armed_next      = armed_reg;
        reload_next     = reload_reg;
        level_hold_next = level_hold_reg;
        irq_next        = 1'b0;
        reload_out_next = reload_reg;
        len_dec         = length_cnt_reg - {{(WORD_W-1){1'b0}}, 1'b1};

        case (cmd_reg)
            CMD_TICK:
            begin
                // pwm gate step
                if (phase_inc == VOL_FULL) begin
                    phase_next = '0;
                    gate_next  = (vol_hold_reg != '0);
                end else begin
                    phase_next = phase_inc[PHASE_W-1:0];
                    if (phase_inc == vol_hold_reg)
                        gate_next = 1'b0;
                end

                unique case (mode_reg)
                    MODE_DUMMY_WAIT:
                    begin
                        if (!dma)
                            mode_next = MODE_DISABLED;
                        else if (!wanted_reg) begin
                            mode_next   = MODE_DMA_WAIT;
                            wanted_next = 1'b1;
                            if (length_cnt_reg != {{(WORD_W-1){1'b0}}, 1'b1})
                                length_cnt_next = len_dec;
                            irq_next = 1'b1;
                        end
                    end
                    MODE_DMA_WAIT:
                    begin
                        if (!dma)
                            mode_next = MODE_DISABLED;
                        else if (!wanted_reg) begin
                            mode_next       = MODE_HIGH;
                            vol_hold_next   = volume_level_reg;
                            phase_next      = '0;
                            gate_next       = (volume_level_reg != '0);
                            period_cnt_next = period_reload_reg;
                            playing_next    = holding_reg;
                            level_hold_next = holding_reg[WORD_W-1 -: LEVEL_W];
                            if (napnav)
                                wanted_next = 1'b1;
                        end
                    end
                    MODE_HIGH:
                    begin
                        if (period_cnt_reg == {{(WORD_W-1){1'b0}}, 1'b1}) begin
                            mode_next = MODE_LOW;
                            if (attach_period_reg) begin
                                playing_next = holding_reg;
                                if (dma) begin
                                    wanted_next = 1'b1;
                                    if (armed_reg) begin
                                        armed_next = 1'b0;
                                        irq_next   = 1'b1;
                                    end
                                end else
                                    irq_next = 1'b1;
                            end
                            level_hold_next = playing_next[LEVEL_W-1:0];
                            period_cnt_next = period_reload_reg;
                            // word counted only if no fetch is still outstanding
                            if (dma && !wanted_next) begin
                                if (len_dec == '0) begin
                                    length_cnt_next = length_reload_reg;
                                    armed_next      = 1'b1;
                                    reload_next     = 1'b1;
                                end else
                                    length_cnt_next = len_dec;
                            end
                        end else
                            period_cnt_next = period_dec;
                    end
                    MODE_LOW:
                    begin
                        period_cnt_next = period_dec;
                        if (period_dec == '0) begin
                            if (dma || !ip) begin
                                mode_next       = MODE_HIGH;
                                vol_hold_next   = volume_level_reg;
                                phase_next      = '0;
                                gate_next       = (volume_level_reg != '0);
                                period_cnt_next = period_reload_reg;
                                playing_next    = holding_reg;
                                level_hold_next = holding_reg[WORD_W-1 -: LEVEL_W];
                                if (napnav) begin
                                    if (dma) begin
                                        wanted_next = 1'b1;
                                        if (armed_reg) begin
                                            armed_next = 1'b0;
                                            irq_next   = 1'b1;
                                        end
                                    end else
                                        irq_next = 1'b1;
                                end
                                if (dma && !wanted_next) begin
                                    if (len_dec == '0) begin
                                        length_cnt_next = length_reload_reg;
                                        armed_next      = 1'b1;
                                        reload_next     = 1'b1;
                                    end else
                                        length_cnt_next = len_dec;
                                end
                            end else begin
                                mode_next  = MODE_DISABLED;
                                armed_next = 1'b0;
                            end
                        end
                    end
                    default:
                    begin
                        // disabled, and any code that means nothing
                        if (!wanted_reg && !dma && !ip) begin
                            mode_next       = MODE_HIGH;
                            period_cnt_next = period_reload_reg;
                            vol_hold_next   = volume_level_reg;
                            phase_next      = '0;
                            gate_next       = (volume_level_reg != '0);
                            playing_next    = holding_reg;
                            level_hold_next = holding_reg[WORD_W-1 -: LEVEL_W];
                            wanted_next     = 1'b1;
                            irq_next        = 1'b1;
                        end else if (dma) begin
                            mode_next       = MODE_DUMMY_WAIT;
                            period_cnt_next = period_reload_reg;
                            wanted_next     = 1'b1;
                            length_cnt_next = length_reload_reg;
                            reload_next     = 1'b1;
                        end
                    end
                endcase
                reload_out_next = reload_next;
            end
            CMD_DMA_DATA:
            begin
                holding_next = word_reg;
                wanted_next  = 1'b0;
                // pointer reload goes out with this fetch
                reload_next  = 1'b0;
            end
            CMD_CPU_WRITE:
            begin
                holding_next = word_reg;
                wanted_next  = 1'b0;
                phase_next   = '0;
                gate_next    = (vol_hold_reg != '0);
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            period_reload_reg <= '0;
            length_reload_reg <= '0;
            volume_level_reg  <= '0;
            attach_period_reg <= 1'b0;
            attach_volume_reg <= 1'b0;
        end else if (cfg_write_en) begin
            unique case (cfg_index)
                CFG_PERIOD_RELOAD: period_reload_reg <= cfg_data;
                CFG_LENGTH_RELOAD: length_reload_reg <= cfg_data;
                CFG_VOLUME_LEVEL:
                begin
                    if (cfg_data[6])
                        volume_level_reg <= VOL_FULL;
                    else
                        volume_level_reg <= {1'b0, cfg_data[PHASE_W-1:0]};
                end
                CFG_ATTACH_PERIOD: attach_period_reg <= cfg_data[0];
                CFG_ATTACH_VOLUME: attach_volume_reg <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_ready)
            in_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid) begin
            cmd_reg  <= command;
            word_reg <= sample_word;
            dma_reg  <= dma_on;
            ip_reg   <= irq_pending;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg       <= MODE_DISABLED;
            holding_reg    <= '0;
            playing_reg    <= '0;
            period_cnt_reg <= '0;
            length_cnt_reg <= '0;
            vol_hold_reg   <= '0;
            phase_reg      <= '0;
            gate_reg       <= 1'b1;
            wanted_reg     <= 1'b0;
            armed_reg      <= 1'b0;
            reload_reg     <= 1'b0;
            level_hold_reg <= '0;
        end else if (advance) begin
            mode_reg       <= mode_next;
            holding_reg    <= holding_next;
            playing_reg    <= playing_next;
            period_cnt_reg <= period_cnt_next;
            length_cnt_reg <= length_cnt_next;
            vol_hold_reg   <= vol_hold_next;
            phase_reg      <= phase_next;
            gate_reg       <= gate_next;
            wanted_reg     <= wanted_next;
            armed_reg      <= armed_next;
            reload_reg     <= reload_next;
            level_hold_reg <= level_hold_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance) begin
            level_reg      <= level_hold_next;
            gate_out_reg   <= gate_next;
            irq_out_reg    <= irq_next;
            dma_out_reg    <= wanted_next;
            reload_out_reg <= reload_out_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign level          = $signed(level_reg);
    assign level_gate     = gate_out_reg;
    assign irq_request    = irq_out_reg;
    assign dma_request    = dma_out_reg;
    assign pointer_reload = reload_out_reg;

endmodule
